FILE: design/tilb_pkg.sv
// Package for the tagged image line buffer.
// Holds field widths, parameter defaults, item kinds and error codes.
// No dependencies.
package tilb_pkg;

  // Parameter defaults
  localparam int NumSlotsDef       = 4;
  localparam int LineWidthDef      = 1024;
  localparam int LineNumberBitsDef = 12;

  // Port field widths
  localparam int KindW   = 2;
  localparam int LineNoW = 12;
  localparam int SlotW   = 4;
  localparam int ColW    = 12;
  localparam int PixW    = 24;
  localparam int ErrW    = 3;

  typedef enum logic [KindW-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_ASSIGN = 2'd1,
    KIND_READ   = 2'd2,
    KIND_WRITE  = 2'd3
  } kind_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK      = 3'd0,
    ERR_COLUMN  = 3'd1,
    ERR_SLOT    = 3'd2,
    ERR_INVALID = 3'd3,
    ERR_HELD    = 3'd4
  } err_e;

  // One input beat as held in the input register
  typedef struct packed {
    kind_e              kind;
    logic [LineNoW-1:0] line_number;
    logic [SlotW-1:0]   slot_index;
    logic [ColW-1:0]    column;
    logic [PixW-1:0]    pixel;
  } in_beat_t;

endpackage

FILE: design/tagged_image_line_buffer_top.sv
// Top level of the tagged image line buffer: slot tags, tag search and pixel store.
// Depends on tilb_pkg.

// At most one item is accepted per cycle. An accepted item sits in the input
// register until it is processed; its result then goes into the result register,
// from which it can be taken when the output is not stalled. A stalled result
// holds the item behind it in the input register, which then stalls the input.
// Lookup and assign search all slot tags in parallel; the victim for an assign
// is the slot with the smallest tag, invalid slots first, ties to the lower
// index. Pixel reads and writes go through the single read/write port of the
// pixel store, so one access is served per cycle while the output is not
// stalled, and a read sees every earlier write. Bad column, bad slot and
// invalid slot accesses are flagged and dropped. The pixel store is not
// cleared after reset; a pixel must be written before it is read.
module tagged_image_line_buffer_top
  import tilb_pkg::*;
#(
  parameter int NUM_SLOTS        = NumSlotsDef,
  parameter int LINE_WIDTH       = LineWidthDef,
  parameter int LINE_NUMBER_BITS = LineNumberBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [LineNoW-1:0] line_number_i,
  input  logic [SlotW-1:0]   slot_index_i,
  input  logic [ColW-1:0]    column_i,
  input  logic [PixW-1:0]    pixel_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SlotW-1:0]   slot_out_o,
  output logic               found_o,
  output logic [PixW-1:0]    pixel_out_o,
  output logic [ErrW-1:0]    error_code_o
);

  localparam int StoreDepth = NUM_SLOTS * LINE_WIDTH;
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int TagW       = LINE_NUMBER_BITS;
  localparam int KeyW       = TagW + 1;

  // Handshake and pipeline control
  logic     in_accept;
  logic     out_adv;
  logic     s1_valid_q, s1_valid_d;
  in_beat_t s1_q;
  logic     out_valid_q, out_valid_d;
  logic     proc;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign proc       = s1_valid_q && out_adv;

  assign s1_valid_d  = in_accept || (s1_valid_q && !out_adv);
  assign out_valid_d = proc || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.kind        <= kind_e'(kind_i);
      s1_q.line_number <= line_number_i;
      s1_q.slot_index  <= slot_index_i;
      s1_q.column      <= column_i;
      s1_q.pixel       <= pixel_in_i;
    end
  end

  // Fit the line number to the tag width: extend it or cut it
  logic [TagW-1:0] in_tag;
  generate
    if (TagW >= LineNoW) begin : g_tag_ext
      assign in_tag = TagW'(s1_q.line_number);
    end else begin : g_tag_cut
      assign in_tag = s1_q.line_number[TagW-1:0];
    end
  endgenerate

  // Slot tag state
  logic [NUM_SLOTS-1:0]  slot_valid_q, slot_valid_d;
  logic [TagW-1:0]       slot_tag_q [NUM_SLOTS];
  logic [TagW-1:0]       slot_tag_d [NUM_SLOTS];

  // Tag search: hit vector, lowest hit index
  logic [NUM_SLOTS-1:0] hit_vec;
  logic                 hit_any;
  logic [SlotW-1:0]     hit_idx;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit_vec[i] = slot_valid_q[i] && (slot_tag_q[i] == in_tag);
    end
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_idx = SlotW'(i);
    end
    hit_any = |hit_vec;
  end

  // Victim choice: each slot compared against all others, exactly one winner
  logic [KeyW-1:0]      key [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] win;
  logic [SlotW-1:0]     best_idx;

  always_comb begin
    best_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      key[i] = slot_valid_q[i] ? (KeyW'(slot_tag_q[i]) + KeyW'(1)) : '0;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      win[i] = 1'b1;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if ((j < i) && !(key[i] < key[j])) win[i] = 1'b0;
        if ((j > i) && (key[j] < key[i]))  win[i] = 1'b0;
      end
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (win[i]) best_idx = best_idx | SlotW'(i);
    end
  end

  // Access checks for read and write
  logic             col_bad;
  logic             slot_bad;
  logic             sel_valid;
  logic [AddrW-1:0] addr;

  always_comb begin
    sel_valid = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (s1_q.slot_index == SlotW'(i)) sel_valid = slot_valid_q[i];
    end
  end

  assign col_bad  = {1'b0, s1_q.column} >= (ColW + 1)'(LINE_WIDTH);
  assign slot_bad = {1'b0, s1_q.slot_index} >= (SlotW + 1)'(NUM_SLOTS);
  assign addr     = AddrW'(32'(s1_q.slot_index) * 32'(LINE_WIDTH) + 32'(s1_q.column));

  // Decode the item into a result and state updates
  err_e             err_d;
  logic [SlotW-1:0] slot_out_d;
  logic             found_d;
  logic             rd_ok_d;
  logic             wr_ok;

  always_comb begin
    err_d        = ERR_OK;
    slot_out_d   = '0;
    found_d      = 1'b0;
    rd_ok_d      = 1'b0;
    wr_ok        = 1'b0;
    slot_valid_d = slot_valid_q;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_tag_d[i] = slot_tag_q[i];
    end
    unique case (s1_q.kind)
      KIND_LOOKUP: begin
        if (hit_any) begin
          slot_out_d = hit_idx;
          found_d    = 1'b1;
        end
      end
      KIND_ASSIGN: begin
        if (hit_any) begin
          slot_out_d = hit_idx;
          err_d      = ERR_HELD;
        end else begin
          slot_out_d = best_idx;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (win[i]) begin
              slot_valid_d[i] = 1'b1;
              slot_tag_d[i]   = in_tag;
            end
          end
        end
      end
      KIND_READ, KIND_WRITE: begin
        if (col_bad) begin
          err_d = ERR_COLUMN;
        end else if (slot_bad) begin
          err_d = ERR_SLOT;
        end else if (!sel_valid) begin
          err_d = ERR_INVALID;
        end else if (s1_q.kind == KIND_READ) begin
          rd_ok_d = 1'b1;
        end else begin
          wr_ok = 1'b1;
        end
      end
      default: begin
        err_d = ERR_OK;
      end
    endcase
  end

  // Update slot tags on a processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_tag_q[i] <= '0;
      end
    end else if (proc) begin
      slot_valid_q <= slot_valid_d;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_tag_q[i] <= slot_tag_d[i];
      end
    end
  end

  // Pixel store: one port, read data registered with the result
  logic [PixW-1:0] pixel_store [StoreDepth];
  logic [PixW-1:0] mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (proc && wr_ok) begin
      pixel_store[addr] <= s1_q.pixel;
    end
    if (proc && rd_ok_d) begin
      mem_rd_q <= pixel_store[addr];
    end
  end

  // Result register, held while the output is stalled
  err_e             err_q;
  logic [SlotW-1:0] slot_out_q;
  logic             found_q;
  logic             rd_ok_q;

  always_ff @(posedge clk_i) begin
    if (proc) begin
      err_q      <= err_d;
      slot_out_q <= slot_out_d;
      found_q    <= found_d;
      rd_ok_q    <= rd_ok_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign slot_out_o   = slot_out_q;
  assign found_o      = found_q;
  assign pixel_out_o  = rd_ok_q ? mem_rd_q : '0;
  assign error_code_o = err_q;

`ifndef SYNTH
  // Valid slots never share a tag, so a search hits at most one slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $onehot0(hit_vec))
    else $error("tag held by more than one slot");

  // Slots once assigned stay valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((slot_valid_q & $past(slot_valid_q)) == $past(slot_valid_q)))
    else $error("slot valid bit cleared");

  // The victim choice always names exactly one slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $onehot(win))
    else $error("victim choice not unique");

  // A found lookup carries no error and no pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && found_q) |-> (err_q == ERR_OK && !rd_ok_q))
    else $error("found result mixed with error or pixel");

  // A processed assign without a held line makes its slot valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && s1_q.kind == KIND_ASSIGN && !hit_any) |=> (slot_valid_q != '0))
    else $error("assign left no valid slot");
`endif

endmodule
